// ----- rtl/bsam_pkg.sv -----
// Package for the bit-slice ALU microstep block: decode table types and codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bsam_pkg;

   typedef enum logic [2:0] {
      KIND_ALU, KIND_SUM, KIND_SAL, KIND_SAR, KIND_SLL, KIND_SLR, KIND_SCL, KIND_SCR
   } kind_type;

   typedef enum logic [2:0] {
      SRC_NONE, SRC_WR, SRC_XWR, SRC_REG, SRC_IN
   } src_type;

   typedef enum logic [2:0] {
      DST_REG, DST_WR, DST_XWR, DST_OUT, DST_WRX
   } dst_type;

   typedef struct packed {
      logic     hit;
      kind_type kind;
      src_type  src_a;
      src_type  src_b;
      logic     neg_b;
      logic     carry;
      dst_type  dest;
      logic     addr_work;
   } dec_type;

   localparam int unsigned PC_INDEX = 7;

   function automatic dec_type mk(kind_type k, src_type a, src_type b, logic n, logic c,
                                  dst_type d, logic w);
      dec_type r;
      r.hit = 1'b1; r.kind = k; r.src_a = a; r.src_b = b; r.neg_b = n;
      r.carry = c; r.dest = d; r.addr_work = w;
      return r;
   endfunction

   // First match among the fixed microinstruction patterns.
   function automatic dec_type decode(logic [8:0] mi);
      dec_type r;
      r = '0;
      r.kind = KIND_ALU; r.src_a = SRC_NONE; r.src_b = SRC_NONE; r.dest = DST_REG;
      if (mi[4:3] == 2'b00)
         r = mk(KIND_ALU, SRC_REG, SRC_WR, 1'b0, 1'b0, DST_REG, 1'b1);
      else if (mi[4:3] == 2'b01)
         r = mk(KIND_ALU, SRC_REG, SRC_WR, 1'b0, 1'b0, DST_WR, 1'b1);
      else if (mi[4:0] == 5'b11000)
         r = mk(KIND_ALU, SRC_IN, SRC_WR, 1'b0, 1'b0, DST_OUT, 1'b0);
      else if (mi[4:0] == 5'b11001)
         r = mk(KIND_ALU, SRC_IN, SRC_WR, 1'b0, 1'b0, DST_WR, 1'b0);
      else if (mi[4:0] == 5'b11011)
         r = mk(KIND_ALU, SRC_IN, SRC_XWR, 1'b0, 1'b0, DST_WR, 1'b1);
      else if (mi[4:0] == 5'b11100)
         r = mk(KIND_ALU, SRC_IN, SRC_WR, 1'b0, 1'b0, DST_XWR, 1'b1);
      else if (mi[4:0] == 5'b11110)
         r = mk(KIND_ALU, SRC_IN, SRC_XWR, 1'b0, 1'b0, DST_XWR, 1'b1);
      else if (mi[4:0] == 5'b11111)
         r = mk(KIND_ALU, SRC_IN, SRC_XWR, 1'b0, 1'b0, DST_OUT, 1'b1);
      else if (mi[8:3] == 6'b001110)
         r = mk(KIND_SUM, SRC_REG, SRC_WR, 1'b0, 1'b1, DST_XWR, 1'b1);
      else if (mi[8:3] == 6'b010010)
         r = mk(KIND_SUM, SRC_REG, SRC_IN, 1'b0, 1'b1, DST_WR, 1'b1);
      else if (mi[8:3] == 6'b010110)
         r = mk(KIND_SUM, SRC_REG, SRC_IN, 1'b0, 1'b1, DST_XWR, 1'b1);
      else if (mi[8:3] == 6'b011110)
         r = mk(KIND_SUM, SRC_REG, SRC_IN, 1'b0, 1'b1, DST_REG, 1'b1);
      else if (mi[8:3] == 6'b110010)
         r = mk(KIND_SUM, SRC_REG, SRC_XWR, 1'b0, 1'b1, DST_WR, 1'b1);
      else if (mi[8:3] == 6'b110110)
         r = mk(KIND_SUM, SRC_REG, SRC_XWR, 1'b0, 1'b1, DST_XWR, 1'b1);
      else if (mi[8:3] == 6'b111010)
         r = mk(KIND_SUM, SRC_XWR, SRC_NONE, 1'b0, 1'b1, DST_REG, 1'b1);
      else if (mi == 9'b001111010)
         r = mk(KIND_SUM, SRC_WR, SRC_IN, 1'b0, 1'b1, DST_XWR, 1'b1);
      else if (mi == 9'b011111010)
         r = mk(KIND_SUM, SRC_WR, SRC_IN, 1'b0, 1'b1, DST_OUT, 1'b1);
      else if (mi == 9'b110011010)
         r = mk(KIND_SUM, SRC_XWR, SRC_IN, 1'b0, 1'b1, DST_WR, 1'b1);
      else if (mi == 9'b110111010)
         r = mk(KIND_SUM, SRC_XWR, SRC_IN, 1'b0, 1'b1, DST_XWR, 1'b1);
      else if (mi == 9'b111011010)
         r = mk(KIND_SUM, SRC_XWR, SRC_NONE, 1'b0, 1'b1, DST_OUT, 1'b1);
      else if (mi[8:3] == 6'b111110)
         r = mk(KIND_SUM, SRC_IN, SRC_NONE, 1'b0, 1'b0, DST_REG, 1'b1);
      else if (mi[8:3] == 6'b000010)
         r = mk(KIND_SUM, SRC_REG, SRC_NONE, 1'b0, 1'b0, DST_OUT, 1'b1);
      else if (mi[8:3] == 6'b000110)
         r = mk(KIND_SUM, SRC_REG, SRC_NONE, 1'b0, 1'b0, DST_XWR, 1'b1);
      else if (mi[8:3] == 6'b011010)
         r = mk(KIND_SUM, SRC_IN, SRC_NONE, 1'b0, 1'b0, DST_WR, 1'b1);
      else if (mi == 9'b011011010)
         r = mk(KIND_SUM, SRC_IN, SRC_NONE, 1'b0, 1'b0, DST_WR, 1'b1);
      else if (mi == 9'b000111010)
         r = mk(KIND_SUM, SRC_IN, SRC_NONE, 1'b0, 1'b0, DST_XWR, 1'b1);
      else if (mi == 9'b111111010)
         r = mk(KIND_SUM, SRC_IN, SRC_NONE, 1'b0, 1'b0, DST_OUT, 1'b1);
      else if (mi == 9'b000011010)
         r = mk(KIND_SUM, SRC_IN, SRC_NONE, 1'b0, 1'b0, DST_OUT, 1'b1);
      else if (mi == 9'b100011010)
         r = mk(KIND_SCL, SRC_WR, SRC_IN, 1'b1, 1'b1, DST_WRX, 1'b1);
      else if (mi == 9'b100111010)
         r = mk(KIND_SCL, SRC_WR, SRC_IN, 1'b0, 1'b1, DST_WRX, 1'b1);
      else if (mi[8:3] == 6'b100010)
         r = mk(KIND_SCL, SRC_WR, SRC_REG, 1'b1, 1'b1, DST_WRX, 1'b1);
      else if (mi[8:3] == 6'b100110)
         r = mk(KIND_SCL, SRC_WR, SRC_REG, 1'b0, 1'b1, DST_WRX, 1'b1);
      else if (mi[8:3] == 6'b101010)
         r = mk(KIND_SAR, SRC_WR, SRC_NONE, 1'b0, 1'b1, DST_WRX, 1'b1);
      else if (mi == 9'b101011010)
         r = mk(KIND_SAR, SRC_WR, SRC_NONE, 1'b0, 1'b1, DST_WRX, 1'b1);
      else if (mi == 9'b001011010)
         r = mk(KIND_SAR, SRC_WR, SRC_IN, 1'b1, 1'b1, DST_WRX, 1'b1);
      else if (mi == 9'b101111010)
         r = mk(KIND_SAR, SRC_WR, SRC_IN, 1'b0, 1'b1, DST_WRX, 1'b1);
      else if (mi[8:3] == 6'b001010)
         r = mk(KIND_SAR, SRC_WR, SRC_REG, 1'b1, 1'b1, DST_WRX, 1'b1);
      else if (mi[8:3] == 6'b101110)
         r = mk(KIND_SAR, SRC_WR, SRC_REG, 1'b0, 1'b1, DST_WRX, 1'b1);
      else if (mi == 9'b000011101)
         r = mk(KIND_SAR, SRC_WR, SRC_NONE, 1'b0, 1'b1, DST_WR, 1'b1);
      else if (mi[7:0] == 8'b00111101)
         r = mk(KIND_SCR, SRC_WR, SRC_NONE, 1'b0, 1'b1, DST_WR, 1'b1);
      else if (mi == 9'b001011101)
         r = mk(KIND_SAL, SRC_WR, SRC_NONE, 1'b0, 1'b1, DST_WR, 1'b1);
      else if (mi[7:0] == 8'b01111101)
         r = mk(KIND_SCL, SRC_WR, SRC_NONE, 1'b0, 1'b1, DST_WR, 1'b1);
      else if (mi == 9'b100011101)
         r = mk(KIND_SLR, SRC_WR, SRC_NONE, 1'b0, 1'b1, DST_WR, 1'b1);
      else if (mi == 9'b101011101)
         r = mk(KIND_SLL, SRC_WR, SRC_NONE, 1'b0, 1'b1, DST_WR, 1'b1);
      else if (mi == 9'b010011101)
         r = mk(KIND_SAR, SRC_WR, SRC_NONE, 1'b0, 1'b1, DST_WRX, 1'b1);
      else if (mi[7:0] == 8'b10111101)
         r = mk(KIND_SCR, SRC_WR, SRC_NONE, 1'b0, 1'b1, DST_WRX, 1'b1);
      else if (mi == 9'b011011101)
         r = mk(KIND_SAL, SRC_WR, SRC_NONE, 1'b0, 1'b1, DST_WRX, 1'b1);
      else if (mi[7:0] == 8'b11111101)
         r = mk(KIND_SCL, SRC_WR, SRC_NONE, 1'b0, 1'b1, DST_WRX, 1'b1);
      else if (mi == 9'b110011101)
         r = mk(KIND_SLR, SRC_WR, SRC_NONE, 1'b0, 1'b1, DST_WRX, 1'b1);
      else if (mi == 9'b111011101)
         r = mk(KIND_SLL, SRC_WR, SRC_NONE, 1'b0, 1'b1, DST_WRX, 1'b1);
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/bsam_if.sv -----
// Valid/ready channel interface carrying one item of payload type.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface bsam_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/bsam_shift.sv -----
// Shifter for single and double precision shifts of the work:extension pair.
// Depends on bsam_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bsam_shift
   import bsam_pkg::*;
#(
   parameter int WIDTH = 16
) (
   input  wire kind_type         kind,
   input  wire logic             dbl,
   input  wire logic             p0,
   input  wire logic [WIDTH-1:0] r_in,
   input  wire logic [WIDTH-1:0] x_in,
   output logic      [WIDTH-1:0] r_out,
   output logic      [WIDTH-1:0] x_out,
   output logic      [3:0]       lines_n
);
   // Lines are accumulated active high and inverted at the end.
   logic [3:0] ln;
   logic       sgn;
   logic       lo;
   logic       xb;

   always_comb begin
      ln    = 4'b0000;
      sgn   = r_in[WIDTH-1];
      lo    = r_in[0];
      r_out = r_in;
      x_out = x_in;
      xb    = 1'b0;
      case (kind)
         KIND_SAL: begin
            ln[0] = sgn;
            r_out = {r_in[WIDTH-2:0], 1'b0};
            if (dbl) begin
               xb = p0 ? x_in[WIDTH-1] : x_in[WIDTH-2];
               x_out = {x_in[WIDTH-2:0], 1'b0};
               r_out[0] = xb;
               ln[2] = ln[2] ^ xb;
               ln[1] = ln[1] ^ xb;
               if (!p0) x_out[WIDTH-1] = r_out[WIDTH-1];
            end
         end
         KIND_SAR: begin
            ln[1] = lo;
            r_out = {sgn, r_in[WIDTH-1:1]};
            if (dbl) begin
               ln[3] = x_in[0];
               ln[2] = lo;
               x_out = {1'b0, x_in[WIDTH-1:1]};
               if (p0) begin
                  x_out[WIDTH-1] = lo;
               end else begin
                  x_out[WIDTH-1] = sgn;
                  x_out[WIDTH-2] = lo;
               end
            end
         end
         KIND_SLL: begin
            ln[0] = sgn;
            r_out = {r_in[WIDTH-2:0], 1'b0};
            if (dbl) begin
               xb = x_in[WIDTH-1];
               ln[2] = xb;
               ln[1] = xb;
               x_out = {x_in[WIDTH-2:0], 1'b0};
               r_out[0] = xb;
            end
         end
         KIND_SLR: begin
            ln[1] = lo;
            r_out = {1'b0, r_in[WIDTH-1:1]};
            if (dbl) begin
               ln[3] = x_in[0];
               ln[2] = lo;
               x_out = {lo, x_in[WIDTH-1:1]};
            end
         end
         KIND_SCL: begin
            if (dbl) begin
               xb = x_in[WIDTH-1];
               ln[0] = sgn;
               ln[3] = sgn;
               ln[1] = xb;
               ln[2] = xb;
               r_out = {r_in[WIDTH-2:0], xb};
               x_out = {x_in[WIDTH-2:0], sgn};
            end else begin
               ln[0] = sgn;
               ln[1] = sgn;
               r_out = {r_in[WIDTH-2:0], sgn};
            end
         end
         KIND_SCR: begin
            if (dbl) begin
               xb = x_in[0];
               ln[1] = lo;
               ln[2] = lo;
               ln[3] = xb;
               ln[0] = xb;
               r_out = {xb, r_in[WIDTH-1:1]};
               x_out = {lo, x_in[WIDTH-1:1]};
            end else begin
               ln[0] = lo;
               ln[1] = lo;
               r_out = {lo, r_in[WIDTH-1:1]};
            end
         end
         default: begin
            r_out = r_in;
         end
      endcase
      lines_n = ~ln;
   end
endmodule
`default_nettype wire

// ----- rtl/bit_slice_alu_microstep_top.sv -----
// Bit-slice ALU microstep, one microinstruction per item.
// An accepted item's result is registered directly into the output register.
// Throughput: one item per cycle while the output is not stalled; decode, one WIDTH-bit
// add and one shift lie between the register file and the result register.
// Synchronous reset clears the register file, the work and extension registers, the address
// and extension buffers and the output valid; the output data register is not reset.
`timescale 1ns / 1ps
`default_nettype none
module bit_slice_alu_microstep_top
   import bsam_pkg::*;
#(
   parameter int WIDTH = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   bsam_if.sink      req,
   bsam_if.source    rsp
);
   localparam int NIBS = WIDTH / 4;

   logic [WIDTH-1:0] work_ff, ext_ff, abuf_ff, xbuf_ff;
   logic [WIDTH-1:0] regs_ff [8];
   logic             rsp_valid_ff;
   logic [47:0]      rsp_data_ff;

   logic [8:0]       mi;
   logic [WIDTH-1:0] din, a, b, aa, bb, sum, r, shr, shx, rfin, xfin, pc_in;
   logic             cin, ac;
   logic [NIBS:0]    kc;
   logic [3:0]       nib, lines_n;
   logic             co;
   dec_type          dec;
   logic             take;
   logic [47:0]      rsp_data_in;
   logic [WIDTH-1:0] work_in, ext_in, abuf_in, dout;

   assign take      = req.valid && req.ready;
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

   assign mi  = req.data[8:0];
   assign din = WIDTH'(req.data[24:9]);
   assign dec = decode(mi);

   function automatic logic [WIDTH-1:0] fetch(src_type s, logic [WIDTH-1:0] w,
         logic [WIDTH-1:0] x, logic [WIDTH-1:0] g, logic [WIDTH-1:0] d);
      logic [WIDTH-1:0] v;
      case (s)
         SRC_WR:  v = w;
         SRC_XWR: v = x;
         SRC_REG: v = g;
         SRC_IN:  v = d;
         default: v = '0;
      endcase
      return v;
   endfunction

   always_comb begin
      a = fetch(dec.src_a, work_ff, ext_ff, regs_ff[mi[2:0]], din);
      b = fetch(dec.src_b, work_ff, ext_ff, regs_ff[mi[2:0]], din);
      if (dec.neg_b) b = ~b;
      aa  = a;
      bb  = b;
      cin = dec.carry ? req.data[25] : 1'b0;
      ac  = 1'b1;
      r   = '0;
      if (dec.kind == KIND_ALU) begin
         cin = req.data[25];
         case (mi[8:5])
            4'd0: ac = 1'b0;
            4'd1: aa = ~a;
            4'd2: bb = ~b;
            4'd3: ;
            4'd4: begin aa = b; bb = '0; end
            4'd5: begin aa = ~b; bb = '0; end
            4'd6: bb = '0;
            4'd7: begin aa = ~a; bb = '0; end
            default: ac = 1'b0;
         endcase
      end
      kc[0] = cin;
      for (int i = 0; i < NIBS; i++)
         kc[i+1] = 5'({1'b0, aa[4*i +: 4]} + {1'b0, bb[4*i +: 4]} + {4'b0, kc[i]}) >> 4 != 5'd0;
      sum = aa + bb + WIDTH'(cin);
      nib = '0;
      for (int i = 0; i < NIBS && i < 4; i++) nib[i] = kc[i+1];
      co = kc[NIBS];
      if (dec.kind == KIND_ALU) begin
         case (mi[8:5])
            4'd0:  r = req.data[25] ? '0 : '1;
            4'd8:  r = a & b;
            4'd9:  r = a ^ b;
            4'd10: r = ~(a ^ b);
            4'd11: r = ~a & b;
            4'd12: r = a & ~b;
            4'd13: r = a | ~b;
            4'd14: r = ~a | b;
            4'd15: r = a | b;
            default: r = sum;
         endcase
         if (!ac) begin
            nib = '0;
            co  = 1'b0;
         end
      end else begin
         r = sum;
      end
   end

   bsam_shift #(.WIDTH(WIDTH)) u_shift (
      .kind(dec.kind), .dbl(dec.dest == DST_WRX), .p0(req.data[26]),
      .r_in(r), .x_in(ext_ff), .r_out(shr), .x_out(shx), .lines_n(lines_n)
   );

   always_comb begin
      rfin = r;
      xfin = ext_ff;
      if (dec.kind != KIND_ALU && dec.kind != KIND_SUM) begin
         rfin = shr;
         xfin = shx;
      end
      work_in = work_ff;
      ext_in  = xfin;
      dout    = '0;
      case (dec.dest)
         DST_XWR: ext_in = rfin;
         DST_OUT: dout = rfin;
         DST_WR, DST_WRX: work_in = rfin;
         default: ;
      endcase
      pc_in = regs_ff[PC_INDEX];
      if (dec.dest == DST_REG && mi[2:0] == 3'(PC_INDEX)) pc_in = rfin;
      if (!req.data[27]) pc_in = pc_in + (req.data[28] ? WIDTH'(2) : WIDTH'(1));
      abuf_in = req.data[29] ? pc_in : (dec.addr_work ? work_in : ext_in);
      rsp_data_in = {1'b0, b[WIDTH-1], a[WIDTH-1], xbuf_ff[WIDTH-1], xbuf_ff[0],
                     lines_n, nib, co, 16'(abuf_ff), dec.dest == DST_OUT,
                     16'(dout), 1'b1};
      if (!dec.hit) rsp_data_in = {5'd0, 4'hF, 39'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         work_ff <= '0;
         ext_ff  <= '0;
         abuf_ff <= '0;
         xbuf_ff <= '0;
         for (int i = 0; i < 8; i++) regs_ff[i] <= '0;
      end else begin
         if (take || rsp.ready) rsp_valid_ff <= take;
         if (take) rsp_data_ff <= rsp_data_in;
         if (take && dec.hit) begin
            work_ff <= work_in;
            ext_ff  <= ext_in;
            abuf_ff <= abuf_in;
            xbuf_ff <= ext_in;
            if (dec.dest == DST_REG) regs_ff[mi[2:0]] <= rfin;
            regs_ff[PC_INDEX] <= pc_in;
         end
      end
   end
endmodule
`default_nettype wire

// ----- tb/tb_bit_slice_alu_microstep_top.sv -----
// Testbench for bit_slice_alu_microstep_top: a scoreboard class predicts each result
// from its own copy of the registers; tasks drive items, both sides idle at random.
// Depends on bsam_pkg, bsam_if and bit_slice_alu_microstep_top.
`timescale 1ns / 1ps
module tb_bit_slice_alu_microstep_top;
   import bsam_pkg::*;

   typedef struct packed {
      logic        address_from_pc;
      logic        pc_step_two;
      logic        inhibit_pc_step;
      logic        p0_mode;
      logic        carry_in;
      logic [15:0] data_in;
      logic [8:0]  microinstruction;
   } step_req_t;

   typedef struct packed {
      logic        spare;
      logic        b_high_bit;
      logic        a_high_bit;
      logic        ext_high_bit;
      logic        ext_low_bit;
      logic [3:0]  shift_lines_n;
      logic [3:0]  nibble_carries;
      logic        carry_out;
      logic [15:0] address_out;
      logic        data_out_driven;
      logic [15:0] data_out;
      logic        decoded;
   } step_rsp_t;

   typedef struct {
      logic [8:0] m;
      logic [8:0] v;
      kind_type   k;
      src_type    sa;
      src_type    sb;
      bit         nb;
      bit         cy;
      dst_type    d;
      bit         aw;
   } ucode_row_t;

   localparam logic [3:0] LINE_L1 = 4'd1;
   localparam logic [3:0] LINE_R1 = 4'd2;
   localparam logic [3:0] LINE_L2 = 4'd4;
   localparam logic [3:0] LINE_R2 = 4'd8;

   class microstep_scoreboard;
      ucode_row_t  rows[$];
      logic [15:0] wr, xr, gr[8], abuf, xbuf;
      step_rsp_t   expected_q[$];
      int          mismatches;
      int          checked;
      int          undecoded;

      function new();
         add("aaaa00rrr", KIND_ALU, SRC_REG, SRC_WR, 0, 0, DST_REG, 1);
         add("aaaa01rrr", KIND_ALU, SRC_REG, SRC_WR, 0, 0, DST_WR, 1);
         add("aaaa11000", KIND_ALU, SRC_IN, SRC_WR, 0, 0, DST_OUT, 0);
         add("aaaa11001", KIND_ALU, SRC_IN, SRC_WR, 0, 0, DST_WR, 0);
         add("aaaa11011", KIND_ALU, SRC_IN, SRC_XWR, 0, 0, DST_WR, 1);
         add("aaaa11100", KIND_ALU, SRC_IN, SRC_WR, 0, 0, DST_XWR, 1);
         add("aaaa11110", KIND_ALU, SRC_IN, SRC_XWR, 0, 0, DST_XWR, 1);
         add("aaaa11111", KIND_ALU, SRC_IN, SRC_XWR, 0, 0, DST_OUT, 1);
         add("001110rrr", KIND_SUM, SRC_REG, SRC_WR, 0, 1, DST_XWR, 1);
         add("010010rrr", KIND_SUM, SRC_REG, SRC_IN, 0, 1, DST_WR, 1);
         add("010110rrr", KIND_SUM, SRC_REG, SRC_IN, 0, 1, DST_XWR, 1);
         add("011110rrr", KIND_SUM, SRC_REG, SRC_IN, 0, 1, DST_REG, 1);
         add("110010rrr", KIND_SUM, SRC_REG, SRC_XWR, 0, 1, DST_WR, 1);
         add("110110rrr", KIND_SUM, SRC_REG, SRC_XWR, 0, 1, DST_XWR, 1);
         add("111010rrr", KIND_SUM, SRC_XWR, SRC_NONE, 0, 1, DST_REG, 1);
         add("001111010", KIND_SUM, SRC_WR, SRC_IN, 0, 1, DST_XWR, 1);
         add("011111010", KIND_SUM, SRC_WR, SRC_IN, 0, 1, DST_OUT, 1);
         add("110011010", KIND_SUM, SRC_XWR, SRC_IN, 0, 1, DST_WR, 1);
         add("110111010", KIND_SUM, SRC_XWR, SRC_IN, 0, 1, DST_XWR, 1);
         add("111011010", KIND_SUM, SRC_XWR, SRC_NONE, 0, 1, DST_OUT, 1);
         add("111110rrr", KIND_SUM, SRC_IN, SRC_NONE, 0, 0, DST_REG, 1);
         add("000010rrr", KIND_SUM, SRC_REG, SRC_NONE, 0, 0, DST_OUT, 1);
         add("000110rrr", KIND_SUM, SRC_REG, SRC_NONE, 0, 0, DST_XWR, 1);
         add("011010xxx", KIND_SUM, SRC_IN, SRC_NONE, 0, 0, DST_WR, 1);
         add("011011010", KIND_SUM, SRC_IN, SRC_NONE, 0, 0, DST_WR, 1);
         add("000111010", KIND_SUM, SRC_IN, SRC_NONE, 0, 0, DST_XWR, 1);
         add("111111010", KIND_SUM, SRC_IN, SRC_NONE, 0, 0, DST_OUT, 1);
         add("000011010", KIND_SUM, SRC_IN, SRC_NONE, 0, 0, DST_OUT, 1);
         add("100011010", KIND_SCL, SRC_WR, SRC_IN, 1, 1, DST_WRX, 1);
         add("100111010", KIND_SCL, SRC_WR, SRC_IN, 0, 1, DST_WRX, 1);
         add("100010rrr", KIND_SCL, SRC_WR, SRC_REG, 1, 1, DST_WRX, 1);
         add("100110rrr", KIND_SCL, SRC_WR, SRC_REG, 0, 1, DST_WRX, 1);
         add("101010xxx", KIND_SAR, SRC_WR, SRC_NONE, 0, 1, DST_WRX, 1);
         add("101011010", KIND_SAR, SRC_WR, SRC_NONE, 0, 1, DST_WRX, 1);
         add("001011010", KIND_SAR, SRC_WR, SRC_IN, 1, 1, DST_WRX, 1);
         add("101111010", KIND_SAR, SRC_WR, SRC_IN, 0, 1, DST_WRX, 1);
         add("001010rrr", KIND_SAR, SRC_WR, SRC_REG, 1, 1, DST_WRX, 1);
         add("101110rrr", KIND_SAR, SRC_WR, SRC_REG, 0, 1, DST_WRX, 1);
         add("000011101", KIND_SAR, SRC_WR, SRC_NONE, 0, 1, DST_WR, 1);
         add("x00111101", KIND_SCR, SRC_WR, SRC_NONE, 0, 1, DST_WR, 1);
         add("001011101", KIND_SAL, SRC_WR, SRC_NONE, 0, 1, DST_WR, 1);
         add("x01111101", KIND_SCL, SRC_WR, SRC_NONE, 0, 1, DST_WR, 1);
         add("100011101", KIND_SLR, SRC_WR, SRC_NONE, 0, 1, DST_WR, 1);
         add("101011101", KIND_SLL, SRC_WR, SRC_NONE, 0, 1, DST_WR, 1);
         add("010011101", KIND_SAR, SRC_WR, SRC_NONE, 0, 1, DST_WRX, 1);
         add("x10111101", KIND_SCR, SRC_WR, SRC_NONE, 0, 1, DST_WRX, 1);
         add("011011101", KIND_SAL, SRC_WR, SRC_NONE, 0, 1, DST_WRX, 1);
         add("x11111101", KIND_SCL, SRC_WR, SRC_NONE, 0, 1, DST_WRX, 1);
         add("110011101", KIND_SLR, SRC_WR, SRC_NONE, 0, 1, DST_WRX, 1);
         add("111011101", KIND_SLL, SRC_WR, SRC_NONE, 0, 1, DST_WRX, 1);
         wr = '0; xr = '0; abuf = '0; xbuf = '0;
         foreach (gr[i]) gr[i] = '0;
         mismatches = 0; checked = 0; undecoded = 0;
      endfunction

      function void add(string p, kind_type k, src_type sa, src_type sb, bit nb, bit cy,
                        dst_type d, bit aw);
         ucode_row_t r;
         r.m = '0; r.v = '0;
         for (int j = 0; j < 9; j++) begin
            if (p[j] == "0") r.m[8-j] = 1'b1;
            else if (p[j] == "1") begin
               r.m[8-j] = 1'b1;
               r.v[8-j] = 1'b1;
            end
         end
         r.k = k; r.sa = sa; r.sb = sb; r.nb = nb; r.cy = cy; r.d = d; r.aw = aw;
         rows.push_back(r);
      endfunction

      function logic [15:0] nibble_add(logic [15:0] a, logic [15:0] b, logic c,
                                       output logic [3:0] nib, output logic co);
         logic       k;
         logic [4:0] s;
         k = c;
         for (int i = 0; i < 4; i++) begin
            s = a[4*i +: 4] + b[4*i +: 4] + k;
            k = s[4];
            nib[i] = k;
         end
         co = k;
         return a + b + c;
      endfunction

      function logic [15:0] alu_op(logic [3:0] op, logic [15:0] a, logic [15:0] b, logic c,
                                   output logic [3:0] nib, output logic co);
         nib = '0;
         co = 1'b0;
         if (op[3]) begin
            case (op[2:0])
               3'd0: return a & b;
               3'd1: return a ^ b;
               3'd2: return ~(a ^ b);
               3'd3: return ~a & b;
               3'd4: return a & ~b;
               3'd5: return a | ~b;
               3'd6: return ~a | b;
               default: return a | b;
            endcase
         end
         case (op[2:0])
            3'd0: return c ? 16'h0000 : 16'hFFFF;
            3'd1: return nibble_add(~a, b, c, nib, co);
            3'd2: return nibble_add(a, ~b, c, nib, co);
            3'd3: return nibble_add(a, b, c, nib, co);
            3'd4: return nibble_add(b, 16'h0, c, nib, co);
            3'd5: return nibble_add(~b, 16'h0, c, nib, co);
            3'd6: return nibble_add(a, 16'h0, c, nib, co);
            default: return nibble_add(~a, 16'h0, c, nib, co);
         endcase
      endfunction

      // Shifts r, and the extension register too for double precision.
      function logic [3:0] shift_step(kind_type k, bit dbl, logic p0, inout logic [15:0] r);
         logic [3:0]  ln;
         logic [15:0] x;
         logic        sign, b;
         ln = 4'hF;
         x = xr;
         sign = r[15];
         case (k)
            KIND_SAL: begin
               if (sign) ln ^= LINE_L1;
               r = r << 1;
               if (dbl) begin
                  b = p0 ? x[15] : x[14];
                  x = x << 1;
                  r[0] = b;
                  if (b) ln ^= LINE_L2 | LINE_R1;
                  if (!p0) x[15] = r[15];
               end
            end
            KIND_SAR: begin
               b = r[0];
               if (b) ln ^= LINE_R1;
               r = {sign, r[15:1]};
               if (dbl) begin
                  if (x[0]) ln ^= LINE_R2;
                  if (b) ln ^= LINE_L2;
                  x = x >> 1;
                  if (p0) x[15] = b;
                  else begin
                     x[15] = sign;
                     x[14] = b;
                  end
               end
            end
            KIND_SLL: begin
               if (sign) ln ^= LINE_L1;
               r = r << 1;
               if (dbl) begin
                  b = x[15];
                  if (b) ln ^= LINE_L2 | LINE_R1;
                  x = x << 1;
                  r[0] = b;
               end
            end
            KIND_SLR: begin
               b = r[0];
               if (b) ln ^= LINE_R1;
               r = r >> 1;
               if (dbl) begin
                  if (x[0]) ln ^= LINE_R2;
                  if (b) ln ^= LINE_L2;
                  x = {b, x[15:1]};
               end
            end
            KIND_SCL: begin
               if (dbl) begin
                  b = x[15];
                  if (sign) ln ^= LINE_L1 | LINE_R2;
                  if (b) ln ^= LINE_R1 | LINE_L2;
                  r = {r[14:0], b};
                  x = {x[14:0], sign};
               end else begin
                  if (sign) ln ^= LINE_L1 | LINE_R1;
                  r = {r[14:0], sign};
               end
            end
            default: begin
               sign = r[0];
               if (dbl) begin
                  b = x[0];
                  if (sign) ln ^= LINE_R1 | LINE_L2;
                  if (b) ln ^= LINE_R2 | LINE_L1;
                  r = {b, r[15:1]};
                  x = {sign, x[15:1]};
               end else begin
                  if (sign) ln ^= LINE_L1 | LINE_R1;
                  r = {sign, r[15:1]};
               end
            end
         endcase
         xr = x;
         return ln;
      endfunction

      function logic [15:0] operand(src_type s, logic [2:0] ri, logic [15:0] din);
         case (s)
            SRC_WR:  return wr;
            SRC_XWR: return xr;
            SRC_REG: return gr[ri];
            SRC_IN:  return din;
            default: return 16'h0;
         endcase
      endfunction

      function void note_input(step_req_t q);
         step_rsp_t   e;
         ucode_row_t  r;
         bit          hit;
         logic [15:0] a, b, res;
         logic [3:0]  nib, ln;
         logic        co;
         logic [2:0]  ri;
         hit = 0;
         e = '0;
         ri = q.microinstruction[2:0];
         foreach (rows[i]) begin
            if (!hit && (q.microinstruction & rows[i].m) == rows[i].v) begin
               hit = 1;
               r = rows[i];
            end
         end
         if (!hit) begin
            e.shift_lines_n = 4'hF;
            undecoded++;
            expected_q.push_back(e);
            return;
         end
         a = operand(r.sa, ri, q.data_in);
         b = operand(r.sb, ri, q.data_in);
         if (r.nb) b = ~b;
         nib = '0; co = 1'b0; ln = 4'hF;
         if (r.k == KIND_ALU) begin
            res = alu_op(q.microinstruction[8:5], a, b, q.carry_in, nib, co);
         end else begin
            res = nibble_add(a, b, r.cy ? q.carry_in : 1'b0, nib, co);
            if (r.k != KIND_SUM) ln = shift_step(r.k, r.d == DST_WRX, q.p0_mode, res);
         end
         case (r.d)
            DST_REG: gr[ri] = res;
            DST_XWR: xr = res;
            DST_OUT: e.data_out = res;
            default: wr = res;
         endcase
         if (!q.inhibit_pc_step) gr[PC_INDEX] = gr[PC_INDEX] + (q.pc_step_two ? 16'd2 : 16'd1);
         e.decoded = 1'b1;
         e.data_out_driven = (r.d == DST_OUT);
         e.address_out = abuf;
         e.carry_out = co;
         e.nibble_carries = nib;
         e.shift_lines_n = ln;
         e.ext_low_bit = xbuf[0];
         e.ext_high_bit = xbuf[15];
         e.a_high_bit = a[15];
         e.b_high_bit = b[15];
         abuf = q.address_from_pc ? gr[PC_INDEX] : (r.aw ? wr : xr);
         xbuf = xr;
         expected_q.push_back(e);
      endfunction

      function void check_result(step_rsp_t got);
         step_rsp_t e;
         bit        bad;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item %p", got);
            return;
         end
         e = expected_q.pop_front();
         checked++;
         bad = got.decoded !== e.decoded || got.data_out !== e.data_out
            || got.data_out_driven !== e.data_out_driven || got.address_out !== e.address_out
            || got.carry_out !== e.carry_out || got.nibble_carries !== e.nibble_carries
            || got.shift_lines_n !== e.shift_lines_n || got.ext_low_bit !== e.ext_low_bit
            || got.ext_high_bit !== e.ext_high_bit || got.a_high_bit !== e.a_high_bit
            || got.b_high_bit !== e.b_high_bit;
         if (bad) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch on result %0d: expected %p, got %p", checked, e, got);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   sent = 0;
   microstep_scoreboard sb = new();

   bsam_if #(.payload_type(step_req_t)) req_ch ();
   bsam_if #(.payload_type(step_rsp_t)) rsp_ch ();

   bit_slice_alu_microstep_top #(.WIDTH(16)) dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch)
   );

   always #4 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.data);
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_item(step_req_t q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= q;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_input(q);
      sent++;
   endtask

   task automatic send_code(logic [8:0] mi, logic [15:0] din, logic c, logic p0);
      step_req_t q;
      q.microinstruction = mi;
      q.data_in = din;
      q.carry_in = c;
      q.p0_mode = p0;
      q.inhibit_pc_step = 1'($urandom_range(1));
      q.pc_step_two = 1'($urandom_range(1));
      q.address_from_pc = 1'($urandom_range(1));
      send_item(q);
   endtask

   function automatic logic [15:0] pick_data();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         3: return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_random(int n);
      logic [8:0] mi;
      int         pick;
      repeat (n) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            pick = $urandom_range(sb.rows.size() - 1);
            mi = (9'($urandom) & ~sb.rows[pick].m) | sb.rows[pick].v;
         end else if (pick < 88) begin
            mi = {4'($urandom), ($urandom_range(1) ? 5'b11010 : 5'b11101)};
         end else begin
            mi = 9'($urandom);
         end
         send_code(mi, pick_data(), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int op = 0; op < 16; op++)
         send_code({4'(op), 5'b11001}, (op % 2) ? 16'hFFFF : 16'h8001, op[1], 1'b0);
      send_code(9'b010011010, 16'hFFFF, 1'b1, 1'b1);
      send_code(9'b111111010, 16'hFFFF, 1'b1, 1'b0);
      send_code(9'b111011010, 16'h0000, 1'b1, 1'b0);
      send_code(9'b010011101, 16'h0000, 1'b1, 1'b0);
      send_code(9'b010011101, 16'h0000, 1'b0, 1'b1);
      send_code(9'b011011101, 16'h0000, 1'b1, 1'b1);
      send_code(9'b011011101, 16'h0000, 1'b0, 1'b0);
      send_code(9'b110111101, 16'h0000, 1'b1, 1'b0);
      wait_drained();
      send_idle_pct = 35; recv_idle_pct = 46;
      send_random(500);
      send_idle_pct = 46; recv_idle_pct = 35;
      send_random(500);
      send_idle_pct = 0; recv_idle_pct = 0;
      send_random(500);
      wait_drained();
      repeat (5) @(posedge clock);
      $display("Sent %0d items, %0d results checked, %0d of them for undecoded codes.",
               sent, sb.checked, sb.undecoded);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0)
         $display("tb_bit_slice_alu_microstep_top passed");
      else
         $display("tb_bit_slice_alu_microstep_top failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d results outstanding", sb.expected_q.size());
      $display("tb_bit_slice_alu_microstep_top failed");
      $finish;
   end
endmodule

// ----- bit_slice_alu_microstep_top.f -----
rtl/bsam_pkg.sv
rtl/bsam_if.sv
rtl/bsam_shift.sv
rtl/bit_slice_alu_microstep_top.sv
tb/tb_bit_slice_alu_microstep_top.sv
